// ===== rtl/atbl_pkg.sv =====
// atbl_pkg: types, constants and helpers for the adaptive token bucket limiter
// no dependencies
`default_nettype none
package atbl_pkg;
    localparam int TICK_SHIFT_DEF    = 10;
    localparam int ADJUST_PERIOD_DEF = 100;
    localparam int WINDOW_SIZE_DEF   = 1000;

    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_ACQUIRE  = 2'd1;
    localparam logic [1:0] OP_RESPONSE = 2'd2;
    localparam logic [1:0] OP_NOP      = 2'd3;

    localparam logic [1:0] REG_INIT_RATE = 2'd0;
    localparam logic [1:0] REG_CAPACITY  = 2'd1;
    localparam logic [1:0] REG_MAX_RATE  = 2'd2;
    localparam logic [1:0] REG_ADAPTIVE  = 2'd3;

    localparam logic [23:0] MIN_RATE   = 24'd26;
    localparam logic [23:0] FLOOR_RATE = 24'd256;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] rtt_ms;
        logic        probe_lost;
    } in_item_t;

    typedef struct packed {
        logic        granted;
        logic [13:0] wait_ticks;
        logic [23:0] current_rate;
        logic [15:0] token_level;
        logic [18:0] srtt_q3;
        logic [17:0] rttvar_q2;
        logic [9:0]  sample_total;
        logic [9:0]  loss_total;
    } out_item_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
        logic div_start;
        logic div_step;
        logic adj_mul;
        logic adj_apply;
    } dp_cmd_t;

    typedef struct packed {
        logic is_deny;
        logic do_adjust;
        logic div_last;
    } dp_status_t;
endpackage
`default_nettype wire

// ===== rtl/atbl_datapath.sv =====
// atbl_datapath: bucket, rate, rtt estimates, counters and serial divider
// depends on atbl_pkg
`default_nettype none
module atbl_datapath #(
    parameter int TICK_SHIFT    = atbl_pkg::TICK_SHIFT_DEF,
    parameter int ADJUST_PERIOD = atbl_pkg::ADJUST_PERIOD_DEF,
    parameter int WINDOW_SIZE   = atbl_pkg::WINDOW_SIZE_DEF
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   cfg_valid,
    input  wire [1:0]             cfg_index,
    input  wire [23:0]            cfg_data,
    input  atbl_pkg::in_item_t    item,
    input  atbl_pkg::dp_cmd_t     cmd,
    output atbl_pkg::dp_status_t  status,
    output atbl_pkg::out_item_t   result
);
    import atbl_pkg::*;

    localparam int FRAC = 8 + TICK_SHIFT;
    localparam int TW   = 16 + FRAC;
    localparam int CW   = $clog2(ADJUST_PERIOD + 1);

    logic [23:0] init_rate_reg, max_rate_reg;
    logic [15:0] cap_reg;
    logic        adaptive_reg;
    logic [TW-1:0] tok_reg;
    logic [23:0] rate_reg;
    logic [18:0] srtt_reg;
    logic        srtt_ok_reg;
    logic [17:0] rttvar_reg;
    logic [9:0]  samp_reg, loss_reg;
    logic [CW-1:0] adj_reg;
    in_item_t    it_reg;
    logic [33:0] prod_reg;
    logic        dec_reg;

    logic [23:0]     rem_reg;
    logic [FRAC-2:0] quo_reg;
    logic [FRAC-1:0] num_reg;
    logic [4:0]      bit_reg;
    logic [13:0]     wait_reg;
    logic            granted_reg;

    logic [TW-1:0] cap_units, one_units, tok_sum;
    logic [TW:0]   tok_add;
    logic [23:0]   ceil_rate, init_cl;
    logic [21:0]   r8;
    logic [21:0]   diff;
    logic [9:0]    samp_n, loss_n;
    logic [CW-1:0] adj_n;
    logic [24:0]   rem_sh;
    logic          rem_fit;
    logic [23:0]   rem_sub;
    logic [33:0]   up_top;

    always_comb
    begin
        cap_units = TW'({(cap_reg == 16'd0) ? 16'd1 : cap_reg}) << FRAC;
        one_units = TW'(1) << FRAC;
        tok_add   = {1'b0, tok_reg} + (TW+1)'(rate_reg);
        tok_sum   = (tok_add > {1'b0, cap_units}) ? cap_units : tok_add[TW-1:0];
        init_cl   = (init_rate_reg < MIN_RATE) ? MIN_RATE : init_rate_reg;
        ceil_rate = (max_rate_reg > init_cl) ? max_rate_reg : init_cl;
        r8        = {it_reg.rtt_ms, 3'b000};
        diff      = ({3'b0, srtt_reg} > r8) ? ({3'b0, srtt_reg} - r8)
                                            : (r8 - {3'b0, srtt_reg});
        samp_n    = samp_reg + 10'd1;
        loss_n    = loss_reg + 10'(it_reg.probe_lost);
        adj_n     = adj_reg + CW'(1);
        rem_sh    = {rem_reg, num_reg[FRAC-1]};
        rem_fit   = rem_sh >= {1'b0, rate_reg};
        rem_sub   = 24'(rem_sh - {1'b0, rate_reg});
        up_top    = 34'(ceil_rate) << 8;
        status.is_deny   = (it_reg.opcode == OP_ACQUIRE) && (tok_reg < one_units);
        status.do_adjust = (it_reg.opcode == OP_RESPONSE) && adaptive_reg
                           && (32'(adj_n) >= 32'(ADJUST_PERIOD));
        status.div_last  = (bit_reg == 5'd0);
    end

    // wait = floor((need - 1) / rate) + 1, need - 1 is the complement of the
    // fraction bits while the bucket holds less than one token
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            it_reg <= item;
        if (cmd.adj_mul)
        begin
            dec_reg  <= (16'd20 * 16'(loss_reg)) > 16'(samp_reg);
            prod_reg <= 34'(rate_reg) * (((16'd20 * 16'(loss_reg)) > 16'(samp_reg))
                         ? 34'd179 : 34'd269);
        end
        if (cmd.div_start)
        begin
            num_reg <= ~tok_reg[FRAC-1:0];
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            num_reg <= num_reg << 1;
            rem_reg <= rem_fit ? rem_sub : rem_sh[23:0];
            quo_reg <= {quo_reg[FRAC-3:0], rem_fit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_rate_reg <= 24'd25600;
            cap_reg       <= 16'd16;
            max_rate_reg  <= 24'd256000;
            adaptive_reg  <= 1'b0;
            tok_reg       <= TW'(16) << FRAC;
            rate_reg      <= 24'd25600;
            srtt_reg      <= '0;
            srtt_ok_reg   <= 1'b0;
            rttvar_reg    <= '0;
            samp_reg      <= '0;
            loss_reg      <= '0;
            adj_reg       <= '0;
            bit_reg       <= '0;
            wait_reg      <= '0;
            granted_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_INIT_RATE:
                    begin
                        init_rate_reg <= cfg_data;
                        rate_reg <= (cfg_data < MIN_RATE) ? MIN_RATE : cfg_data;
                    end
                    REG_CAPACITY:
                    begin
                        cap_reg <= cfg_data[15:0];
                        if (tok_reg > (TW'({(cfg_data[15:0] == 16'd0) ? 16'd1
                                              : cfg_data[15:0]}) << FRAC))
                            tok_reg <= TW'({(cfg_data[15:0] == 16'd0) ? 16'd1
                                            : cfg_data[15:0]}) << FRAC;
                    end
                    REG_MAX_RATE: max_rate_reg <= cfg_data;
                    REG_ADAPTIVE: adaptive_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (cmd.div_start)
                bit_reg <= 5'(FRAC - 1);
            else if (cmd.div_step && bit_reg != 5'd0)
                bit_reg <= bit_reg - 5'd1;
            if (cmd.div_step && status.div_last)
                wait_reg <= 14'({1'b0, quo_reg, rem_fit} + (FRAC+1)'(1));
            if (cmd.exec)
            begin
                granted_reg <= 1'b0;
                wait_reg    <= '0;
                case (it_reg.opcode)
                    OP_TICK: tok_reg <= tok_sum;
                    OP_ACQUIRE:
                        if (!status.is_deny)
                        begin
                            tok_reg     <= tok_reg - one_units;
                            granted_reg <= 1'b1;
                        end
                    OP_RESPONSE:
                        if (adaptive_reg)
                        begin
                            if (!it_reg.probe_lost)
                            begin
                                srtt_ok_reg <= 1'b1;
                                if (!srtt_ok_reg)
                                begin
                                    srtt_reg   <= 19'(r8);
                                    rttvar_reg <= {1'b0, it_reg.rtt_ms, 1'b0};
                                end
                                else
                                begin
                                    srtt_reg   <= 19'((25'(srtt_reg) * 25'd7
                                                       + 25'(r8)) >> 3);
                                    rttvar_reg <= 18'((25'(rttvar_reg) * 25'd6
                                                       + 25'(diff)) >> 3);
                                end
                            end
                            samp_reg <= samp_n;
                            loss_reg <= loss_n;
                            adj_reg  <= status.do_adjust ? '0 : adj_n;
                        end
                    default: ;
                endcase
            end
            if (cmd.adj_apply)
            begin
                if (dec_reg)
                    rate_reg <= (prod_reg[33:8] < 26'(FLOOR_RATE)) ? FLOOR_RATE
                                : prod_reg[31:8];
                else if (100 * 32'(loss_reg) < 32'(samp_reg))
                    rate_reg <= (prod_reg > up_top) ? ceil_rate : prod_reg[31:8];
                if (32'(samp_reg) >= 32'(WINDOW_SIZE))
                begin
                    samp_reg <= '0;
                    loss_reg <= '0;
                    adj_reg  <= '0;
                end
            end
        end
    end

    always_comb
    begin
        result.granted      = granted_reg;
        result.wait_ticks   = wait_reg;
        result.current_rate = rate_reg;
        result.token_level  = tok_reg[TW-1:FRAC];
        result.srtt_q3      = srtt_reg;
        result.rttvar_q2    = rttvar_reg;
        result.sample_total = samp_reg;
        result.loss_total   = loss_reg;
    end
endmodule
`default_nettype wire

// ===== rtl/atbl_ctrl.sv =====
// atbl_ctrl: sequencing state machine for the limiter
// depends on atbl_pkg
`default_nettype none
module atbl_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  wire                  out_stall,
    input  atbl_pkg::dp_status_t status,
    output atbl_pkg::dp_cmd_t    cmd
);
    import atbl_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_APPL = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_stall   = (state_reg != S_IDLE);
        out_valid  = (state_reg == S_OUT);
        case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (status.is_deny)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else if (status.do_adjust)
                    state_next = S_MUL;
                else
                    state_next = S_OUT;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = S_OUT;
            end
            S_MUL:
            begin
                cmd.adj_mul = 1'b1;
                state_next  = S_APPL;
            end
            S_APPL:
            begin
                cmd.adj_apply = 1'b1;
                state_next    = S_OUT;
            end
            S_OUT:
                if (!out_stall)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end
endmodule
`default_nettype wire

// ===== rtl/adaptive_token_bucket_limiter.sv =====
// adaptive_token_bucket_limiter: top level, controller plus datapath
// depends on atbl_pkg, atbl_ctrl, atbl_datapath
//
// usage: one input beat (opcode, rtt_ms, probe_lost) gives one output beat
// with the grant, wait ticks and the limiter state after the item.
// both channels use valid/stall; the block stalls its input while an item is
// in flight and takes one item at a time.
// sequence: an item is loaded, executed and then held as the output beat for
// tick, grant, nop and plain responses; a response that ends an adjust period
// adds a rate multiply and an apply step, and a denied acquire adds the one
// bit per cycle restoring divider for its 8 + TICK_SHIFT quotient bits.
// a new item is taken only after the output beat of the last one is accepted.
// an output beat holds while out_stall is high; no new item is taken then.
// configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, always
// ready; write only while idle. reset loads register defaults and a full
// bucket.
`default_nettype none
module adaptive_token_bucket_limiter #(
    parameter int TICK_SHIFT    = atbl_pkg::TICK_SHIFT_DEF,
    parameter int ADJUST_PERIOD = atbl_pkg::ADJUST_PERIOD_DEF,
    parameter int WINDOW_SIZE   = atbl_pkg::WINDOW_SIZE_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_stall,
    input  atbl_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  wire                 out_stall,
    output atbl_pkg::out_item_t out_data,
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire [1:0]           cfg_index,
    input  wire [23:0]          cfg_data
);
    import atbl_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    atbl_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .status(status), .cmd(cmd)
    );

    atbl_datapath #(
        .TICK_SHIFT(TICK_SHIFT), .ADJUST_PERIOD(ADJUST_PERIOD),
        .WINDOW_SIZE(WINDOW_SIZE)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid && cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .item(in_data),
        .cmd(cmd), .status(status), .result(out_data)
    );
endmodule
`default_nettype wire

// ===== rtl/atbl_checker.sv =====
// atbl_checker: port level assertions for the limiter, bound to the top level
// depends on atbl_pkg
`default_nettype none
module atbl_checker (
    input wire                 clk,
    input wire                 rst_n,
    input wire                 in_valid,
    input wire                 in_stall,
    input wire                 out_valid,
    input wire                 out_stall,
    input atbl_pkg::out_item_t out_data
);
    import atbl_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output beat changed under stall");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item taken while busy");

    a_grant_wait: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.granted |-> out_data.wait_ticks == 14'd0)
        else $error("grant with wait");

    a_rate_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.current_rate >= MIN_RATE)
        else $error("rate below floor");
endmodule

bind adaptive_token_bucket_limiter atbl_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire

// ===== dv/tb.sv =====
// tb: self-checking testbench for adaptive_token_bucket_limiter
// depends on atbl_pkg and the limiter rtl; predicts every output beat in-line
`default_nettype none
module tb;
    import atbl_pkg::*;

    localparam int FRAC = TICK_SHIFT_DEF + 8;

    typedef struct packed {
        in_item_t    item;
        logic        chk;
        logic        granted;
        logic [13:0] wait_ticks;
        logic [15:0] level;
    } dir_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    in_item_t   in_data = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_item_t  out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [23:0] cfg_data = '0;

    // limiter state mirror
    logic [23:0] init_rate_q;
    logic [15:0] capacity_q;
    logic [23:0] max_rate_q;
    logic        adaptive_q;
    logic [63:0] bucket_units;
    logic [23:0] rate_q;
    int unsigned srtt_q, rttvar_q, samples_q, losses_q, period_q;
    logic        srtt_seen;

    out_item_t   pending_beats[$];
    int          send_idle_pct, recv_stall_pct;
    int          mismatches, stray_beats, beats_seen, items_sent;
    int          grants, denials, rate_cuts, rate_raises, window_clears;
    dir_row_t    dir_rows[12];

    always #6 clk = ~clk;

    adaptive_token_bucket_limiter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic logic [63:0] bucket_limit();
        logic [63:0] c;
        c = (capacity_q == 16'd0) ? 64'd1 : {48'd0, capacity_q};
        return c << FRAC;
    endfunction

    function automatic logic [23:0] floor_rate(logic [23:0] r);
        return (r < MIN_RATE) ? MIN_RATE : r;
    endfunction

    task automatic limiter_reset();
        init_rate_q  = 24'd25600;
        capacity_q   = 16'd16;
        max_rate_q   = 24'd256000;
        adaptive_q   = 1'b0;
        bucket_units = bucket_limit();
        rate_q       = floor_rate(init_rate_q);
        srtt_q = 0; rttvar_q = 0; samples_q = 0; losses_q = 0; period_q = 0;
        srtt_seen = 1'b0;
    endtask

    task automatic limiter_config(logic [1:0] idx, logic [23:0] val);
        case (idx)
            REG_INIT_RATE:
            begin
                init_rate_q = val;
                rate_q = floor_rate(val);
            end
            REG_CAPACITY:
            begin
                capacity_q = val[15:0];
                if (bucket_units > bucket_limit())
                    bucket_units = bucket_limit();
            end
            REG_MAX_RATE: max_rate_q = val;
            REG_ADAPTIVE: adaptive_q = val[0];
            default: ;
        endcase
    endtask

    function automatic void take_sample(logic [15:0] rtt, logic lost);
        int unsigned r8, diff;
        logic [63:0] n;
        logic [23:0] top;
        r8 = {13'd0, rtt, 3'd0};
        if (!lost)
        begin
            if (!srtt_seen)
            begin
                srtt_q = r8;
                rttvar_q = {15'd0, rtt, 1'b0};
                srtt_seen = 1'b1;
            end
            else
            begin
                diff = (srtt_q > r8) ? srtt_q - r8 : r8 - srtt_q;
                rttvar_q = (6 * rttvar_q + diff) >> 3;
                srtt_q = (7 * srtt_q + r8) >> 3;
            end
        end
        samples_q++;
        if (lost)
            losses_q++;
        period_q++;
        if (period_q < ADJUST_PERIOD_DEF)
            return;
        period_q = 0;
        if (20 * losses_q > samples_q)
        begin
            n = ({40'd0, rate_q} * 64'd179) >> 8;
            rate_q = (n < FLOOR_RATE) ? FLOOR_RATE : n[23:0];
            rate_cuts++;
        end
        else if (100 * losses_q < samples_q)
        begin
            n = ({40'd0, rate_q} * 64'd269) >> 8;
            top = (max_rate_q > floor_rate(init_rate_q)) ? max_rate_q
                                                         : floor_rate(init_rate_q);
            rate_q = (n > {40'd0, top}) ? top : n[23:0];
            rate_raises++;
        end
        if (samples_q >= WINDOW_SIZE_DEF)
        begin
            samples_q = 0; losses_q = 0; period_q = 0;
            window_clears++;
        end
    endfunction

    function automatic out_item_t limiter_step(in_item_t it);
        out_item_t   o;
        logic [63:0] one, need, t;
        one = 64'd1 << FRAC;
        o = '0;
        case (it.opcode)
            OP_TICK:
            begin
                t = bucket_units + {40'd0, rate_q};
                bucket_units = (t > bucket_limit()) ? bucket_limit() : t;
            end
            OP_ACQUIRE:
            begin
                if (bucket_units >= one)
                begin
                    bucket_units -= one;
                    o.granted = 1'b1;
                    grants++;
                end
                else
                begin
                    need = one - bucket_units;
                    t = (need + {40'd0, rate_q} - 64'd1) / {40'd0, rate_q};
                    o.wait_ticks = t[13:0];
                    denials++;
                end
            end
            OP_RESPONSE:
            begin
                if (adaptive_q)
                    take_sample(it.rtt_ms, it.probe_lost);
            end
            default: ;
        endcase
        o.current_rate = rate_q;
        o.token_level  = bucket_units[FRAC +: 16];
        o.srtt_q3      = srtt_q[18:0];
        o.rttvar_q2    = rttvar_q[17:0];
        o.sample_total = samples_q[9:0];
        o.loss_total   = losses_q[9:0];
        return o;
    endfunction

    task automatic send_beat(in_item_t it, output out_item_t predicted);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (in_stall);
        predicted = limiter_step(it);
        pending_beats.push_back(predicted);
        items_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        limiter_config(idx, val);
        @(posedge clk);
    endtask

    task automatic random_phase(int count, int resp_pct, int loss_pct);
        in_item_t  it;
        out_item_t p;
        int        pick;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(99);
            if (pick < resp_pct)
                it.opcode = OP_RESPONSE;
            else if (pick < resp_pct + (100 - resp_pct) * 45 / 100)
                it.opcode = OP_TICK;
            else if (pick < 96)
                it.opcode = OP_ACQUIRE;
            else
                it.opcode = OP_NOP;
            it.rtt_ms = ($urandom_range(3) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(20, 400));
            it.probe_lost = ($urandom_range(999) < loss_pct * 10);
            send_beat(it, p);
        end
        drain();
    endtask

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
        if (rst_n && out_valid && !out_stall)
        begin
            beats_seen++;
            if (pending_beats.size() == 0)
            begin
                stray_beats++;
                if (mismatches + stray_beats <= 10)
                    $display("unexpected output beat %p", out_data);
            end
            else
            begin
                if (out_data !== pending_beats[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p", pending_beats[0],
                                 out_data);
                end
                void'(pending_beats.pop_front());
            end
        end
    end

    initial
    begin
        #20000000;
        $display("timeout with %0d beats outstanding", pending_beats.size());
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        out_item_t p;
        send_idle_pct = 0; recv_stall_pct = 0;
        mismatches = 0; stray_beats = 0; beats_seen = 0; items_sent = 0;
        grants = 0; denials = 0; rate_cuts = 0; rate_raises = 0; window_clears = 0;
        limiter_reset();
        dir_rows = '{
            '{'{OP_NOP,      16'd0,     1'b0}, 1'b1, 1'b0, 14'd0,     16'd1},
            '{'{OP_ACQUIRE,  16'd0,     1'b0}, 1'b1, 1'b1, 14'd0,     16'd0},
            '{'{OP_ACQUIRE,  16'd0,     1'b0}, 1'b1, 1'b0, 14'd10083, 16'd0},
            '{'{OP_TICK,     16'd0,     1'b0}, 1'b1, 1'b0, 14'd0,     16'd0},
            '{'{OP_ACQUIRE,  16'd0,     1'b0}, 1'b1, 1'b0, 14'd10082, 16'd0},
            '{'{OP_RESPONSE, 16'hffff,  1'b0}, 1'b0, 1'b0, 14'd0,     16'd0},
            '{'{OP_RESPONSE, 16'd0,     1'b0}, 1'b0, 1'b0, 14'd0,     16'd0},
            '{'{OP_RESPONSE, 16'hffff,  1'b1}, 1'b0, 1'b0, 14'd0,     16'd0},
            '{'{OP_RESPONSE, 16'd1234,  1'b0}, 1'b0, 1'b0, 14'd0,     16'd0},
            '{'{OP_NOP,      16'hffff,  1'b1}, 1'b1, 1'b0, 14'd0,     16'd0},
            '{'{OP_TICK,     16'd0,     1'b0}, 1'b0, 1'b0, 14'd0,     16'd0},
            '{'{OP_ACQUIRE,  16'd0,     1'b0}, 1'b0, 1'b0, 14'd0,     16'd0}
        };
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: one-token bucket at the slowest rate
        write_reg(REG_CAPACITY, 24'd1);
        write_reg(REG_INIT_RATE, 24'd26);
        write_reg(REG_ADAPTIVE, 24'd1);
        foreach (dir_rows[i])
        begin
            send_beat(dir_rows[i].item, p);
            if (dir_rows[i].chk && (p.granted !== dir_rows[i].granted ||
                p.wait_ticks !== dir_rows[i].wait_ticks ||
                p.token_level !== dir_rows[i].level))
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("row %0d: predicted %p", i, p);
            end
        end
        drain();

        // loss-free traffic raises the rate toward the top
        write_reg(REG_INIT_RATE, 24'd2000);
        write_reg(REG_CAPACITY, 24'd4);
        write_reg(REG_MAX_RATE, 24'hffffff);
        random_phase(450, 50, 0);

        // heavy loss at the fastest rate, huge bucket
        send_idle_pct = 46;
        write_reg(REG_INIT_RATE, 24'hffffff);
        write_reg(REG_CAPACITY, 24'd65535);
        write_reg(REG_MAX_RATE, 24'd26);
        random_phase(300, 50, 50);

        // responses ignored, zero capacity and rate below the minimum
        send_idle_pct = 0; recv_stall_pct = 46;
        write_reg(REG_ADAPTIVE, 24'd0);
        write_reg(REG_INIT_RATE, 24'd0);
        write_reg(REG_CAPACITY, 24'd0);
        write_reg(REG_MAX_RATE, 24'($urandom));
        random_phase(200, 30, 20);

        // mixed loss around the thresholds
        send_idle_pct = 27; recv_stall_pct = 27;
        write_reg(REG_ADAPTIVE, 24'd1);
        write_reg(REG_INIT_RATE, 24'($urandom_range(26, 5000)));
        write_reg(REG_CAPACITY, 24'($urandom_range(1, 8)));
        write_reg(REG_MAX_RATE, 24'd300000);
        random_phase(900, 60, 3);

        $display("%0d items, %0d beats: %0d grants, %0d denials", items_sent,
                 beats_seen, grants, denials);
        $display("rate cuts %0d, raises %0d, window clears %0d", rate_cuts,
                 rate_raises, window_clears);
        if (mismatches == 0 && stray_beats == 0 && pending_beats.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire
